>>> src/pam_pkg.sv
// shared types, segment thresholds and coefficient tables for the magnitude block
package pam_pkg;

  localparam int unsigned SEG_COUNT   = 9;
  localparam int unsigned THRESH_CNT  = SEG_COUNT - 1;
  localparam int unsigned SEG_W       = $clog2(SEG_COUNT);
  localparam int unsigned THRESH_W    = 8;
  localparam int unsigned COEF_W      = 11;
  localparam int unsigned FRAC_W      = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [SEG_W-1:0] seg_t;

  // segment boundaries on min/max, 8 fraction bits
  localparam logic [THRESH_W-1:0] SEG_THRESH [THRESH_CNT] = '{
    8'd25, 8'd51, 8'd78, 8'd106, 8'd137, 8'd171, 8'd200, 8'd210
  };

  // handshake between the front stage and the queue
  typedef struct packed {
    logic push;
  } pam_push_t;

  function automatic logic [COEF_W-1:0] seg_alpha(input seg_t seg);
    logic [COEF_W-1:0] c;
    case (seg)
      4'd0:    c = 11'd1230;
      4'd1:    c = 11'd1018;
      4'd2:    c = 11'd1001;
      4'd3:    c = 11'd974;
      4'd4:    c = 11'd938;
      4'd5:    c = 11'd895;
      4'd6:    c = 11'd837;
      4'd7:    c = 11'd838;
      default: c = 11'd725;
    endcase
    return c;
  endfunction

  function automatic logic [COEF_W-1:0] seg_beta(input seg_t seg);
    logic [COEF_W-1:0] c;
    case (seg)
      4'd0:    c = 11'd25;
      4'd1:    c = 11'd126;
      4'd2:    c = 11'd225;
      4'd3:    c = 11'd322;
      4'd4:    c = 11'd416;
      4'd5:    c = 11'd505;
      4'd6:    c = 11'd591;
      4'd7:    c = 11'd591;
      default: c = 11'd721;
    endcase
    return c;
  endfunction

endpackage

>>> src/pam_front.sv
// front stage: absolute values, max/min ordering and segment classification
module pam_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        imag_part_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output pam_pkg::seg_t                         seg_o,
  output logic [SAMPLE_WIDTH-1:0]               max_o,
  output logic [SAMPLE_WIDTH-1:0]               min_o
);
  import pam_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned CW = SW + THRESH_W;

  logic [SW-1:0]         abs_re, abs_im, big, little;
  logic [CW-1:0]         little_sc;
  logic [THRESH_CNT-1:0] below;
  seg_t                  seg;
  logic                  load;

  logic                  valid_q, valid_d;
  seg_t                  seg_q;
  logic [SW-1:0]         max_q, min_q;

  // magnitude of the most negative code fits in SW unsigned bits
  assign abs_re = real_part_i[SW-1] ? (~real_part_i + 1'b1) : real_part_i;
  assign abs_im = imag_part_i[SW-1] ? (~imag_part_i + 1'b1) : imag_part_i;

  always_comb begin
    if (abs_im > abs_re) begin
      big    = abs_im;
      little = abs_re;
    end else begin
      big    = abs_re;
      little = abs_im;
    end
  end

  assign little_sc = {little, {THRESH_W{1'b0}}};

  // exact min*256 < t*max per boundary, then first hit wins
  always_comb begin
    for (int k = 0; k < THRESH_CNT; k++) begin
      below[k] = little_sc < (CW'(SEG_THRESH[k]) * CW'(big));
    end
    seg = seg_t'(THRESH_CNT);
    for (int k = THRESH_CNT - 1; k >= 0; k--) begin
      if (below[k]) begin
        seg = seg_t'(k);
      end
    end
  end

  assign busy_o  = valid_q && full_i;
  assign load    = !busy_o;
  assign valid_d = load ? start_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && start_i) begin
      seg_q <= seg;
      max_q <= big;
      min_q <= little;
    end
  end

  assign push_o = valid_q && !full_i;
  assign seg_o  = seg_q;
  assign max_o  = max_q;
  assign min_o  = min_q;

endmodule

>>> src/pam_queue.sv
// short queue that decouples the classifier from the coefficient datapath
module pam_queue #(
  parameter int unsigned DATA_W = 36
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pam_pkg::pam_push_t   ctl_i,
  output logic                 full_o,
  input  logic [DATA_W-1:0]    wdata_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [DATA_W-1:0]    rdata_o
);
  import pam_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = ctl_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> src/pam_back.sv
// back stage: segment coefficients times max and min, then the final sum
module pam_back #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   empty_i,
  output logic                                   pop_o,
  input  pam_pkg::seg_t                          seg_i,
  input  logic [SAMPLE_WIDTH-1:0]                max_i,
  input  logic [SAMPLE_WIDTH-1:0]                min_i,
  output logic                                   done_o,
  output logic [SAMPLE_WIDTH+pam_pkg::FRAC_W-1:0] magnitude_o
);
  import pam_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned PW    = SW + COEF_W;
  localparam int unsigned MAG_W = SW + FRAC_W;

  logic          prod_vld_q;
  logic [PW-1:0] prod_a_q, prod_b_q;
  logic [PW:0]   sum;
  logic          done_q;
  logic [MAG_W-1:0] mag_q;

  // results cannot be held off, so the head is taken whenever present
  assign pop_o = !empty_i;
  assign sum   = {1'b0, prod_a_q} + {1'b0, prod_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= pop_o;
      done_q     <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_a_q <= PW'(seg_alpha(seg_i)) * PW'(max_i);
      prod_b_q <= PW'(seg_beta(seg_i)) * PW'(min_i);
    end
    if (prod_vld_q) begin
      mag_q <= sum[MAG_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign magnitude_o = mag_q;

endmodule

>>> src/piecewise_ambm_magnitude.sv
// Piecewise alpha-max-plus-beta-min magnitude, top level.
// done_o rises once a sample taken with start_i has passed the front register, the queue,
// the product register and the sum register, in that order.
// Throughput: one sample per cycle; the coefficient datapath drains the queue every cycle,
// so the queue never fills and busy_o stays low.
// rst_ni clears valid flags, pointers and counts asynchronously; data registers are not reset.
module piecewise_ambm_magnitude #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0]         real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         imag_part_i,
  output logic                                   done_o,
  output logic [SAMPLE_WIDTH+pam_pkg::FRAC_W-1:0] magnitude_o
);
  import pam_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned DATA_W = SEG_W + 2 * SW;

  pam_push_t         q_ctl;
  logic              q_full, q_empty, q_pop;
  seg_t              f_seg, b_seg;
  logic [SW-1:0]     f_max, f_min, b_max, b_min;
  logic [DATA_W-1:0] q_rdata;

  pam_front #(.SAMPLE_WIDTH(SW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .full_i      (q_full),
    .push_o      (q_ctl.push),
    .seg_o       (f_seg),
    .max_o       (f_max),
    .min_o       (f_min)
  );

  pam_queue #(.DATA_W(DATA_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (q_ctl),
    .full_o  (q_full),
    .wdata_i ({f_seg, f_max, f_min}),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  assign {b_seg, b_max, b_min} = q_rdata;

  pam_back #(.SAMPLE_WIDTH(SW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .seg_i       (b_seg),
    .max_i       (b_max),
    .min_i       (b_min),
    .done_o      (done_o),
    .magnitude_o (magnitude_o)
  );

endmodule

>>> src/pam_checker.sv
// port-level checks for the magnitude block and their binding to the top level
module pam_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   start_i,
  input logic                                   busy_o,
  input logic signed [SAMPLE_WIDTH-1:0]         real_part_i,
  input logic signed [SAMPLE_WIDTH-1:0]         imag_part_i,
  input logic                                   done_o,
  input logic [SAMPLE_WIDTH+pam_pkg::FRAC_W-1:0] magnitude_o
);
  import pam_pkg::*;

  // the back end drains every cycle, so the front never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy_o raised although results are never held off");

  // every result strobe traces back to an accepted input transfer through the pipeline registers
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result strobe without a matching input transfer");

  // a zero sample gives a zero magnitude
  a_zero_in_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(real_part_i == '0 && imag_part_i == '0, 4)) |-> magnitude_o == '0)
    else $error("zero sample produced a nonzero magnitude");

  // a nonzero sample never gives a zero magnitude
  a_nonzero_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(real_part_i != '0 || imag_part_i != '0, 4)) |-> magnitude_o != '0)
    else $error("nonzero sample produced a zero magnitude");

endmodule

bind piecewise_ambm_magnitude pam_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .real_part_i (real_part_i),
  .imag_part_i (imag_part_i),
  .done_o      (done_o),
  .magnitude_o (magnitude_o)
);
